// ===== design/rbii_pkg.sv =====
// rbii_pkg: shared types, constants and codes for the row band interval index
// depends on nothing; imported by every module of the block except rbii_ram

package rbii_pkg;

  localparam int MAX_RECORDS  = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int AW    = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int LIM_W = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [1:0] {
    OPC_CLEAR = 2'd0,
    OPC_ADD   = 2'd1,
    OPC_BUILD = 2'd2,
    OPC_QUERY = 2'd3
  } opcode_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_G_NEXT, ST_G_LAT, ST_G_SCAN, ST_G_CMP,
    ST_S_NEXT, ST_S_LAT, ST_S_SCAN, ST_S_CMP,
    ST_M_NEXT, ST_M_LAT, ST_M_SCAN, ST_M_CMP,
    ST_Q_BS, ST_Q_BSC, ST_Q_SC, ST_Q_SCC, ST_Q_MEM, ST_Q_EMIT, ST_Q_FIN
  } state_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_ACCEPT, OP_G_NEXT, OP_G_LAT, OP_G_SCAN, OP_G_CMP,
    OP_S_NEXT, OP_S_LAT, OP_S_SCAN, OP_S_CMP,
    OP_M_NEXT, OP_M_LAT, OP_M_SCAN, OP_M_CMP,
    OP_Q_BS, OP_Q_BSC, OP_Q_SC, OP_Q_SCC, OP_Q_MEM, OP_Q_EMIT, OP_Q_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic r_end;
    logic j_end;
    logic b_end;
    logic row_match;
    logic lo_lt_hi;
    logic scan_stop;
    logic past_end;
    logic below;
    logic mem_done;
    logic emit_stall;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic signed [31:0] idx;
    logic signed [15:0] row;
    logic signed [31:0] top;
    logic signed [31:0] bot;
  } rec_t;

  typedef struct packed {
    logic signed [15:0] row;
    logic signed [31:0] top;
    logic signed [31:0] bot;
  } band_t;

  typedef struct packed {
    band_t            b;
    logic [CNT_W-1:0] mstart;
    logic [CNT_W-1:0] mcnt;
  } sband_t;

  function automatic logic band_less(band_t a, band_t c);
    logic lt;
    if (a.top != c.top) begin
      lt = a.top < c.top;
    end else if (a.bot != c.bot) begin
      lt = a.bot < c.bot;
    end else begin
      lt = a.row < c.row;
    end
    return lt;
  endfunction

endpackage

// ===== design/rbii_ram.sv =====
// rbii_ram: generic single write port ram with registered read
// depends on nothing

module rbii_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rbii_ctrl.sv =====
// rbii_ctrl: sequencing state machine for clear, add, build and query
// depends on rbii_pkg

module rbii_ctrl import rbii_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  input  status_t    status_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_e'(opcode_i) == OPC_BUILD) state_d = ST_G_NEXT;
          else if (opcode_e'(opcode_i) == OPC_QUERY) state_d = ST_Q_BS;
        end
      end
      ST_G_NEXT: state_d = status_i.r_end ? ST_S_NEXT : ST_G_LAT;
      ST_G_LAT:  state_d = ST_G_SCAN;
      ST_G_SCAN: state_d = status_i.j_end ? ST_G_NEXT : ST_G_CMP;
      ST_G_CMP:  state_d = status_i.row_match ? ST_G_NEXT : ST_G_SCAN;
      ST_S_NEXT: state_d = status_i.b_end ? ST_M_NEXT : ST_S_LAT;
      ST_S_LAT:  state_d = ST_S_SCAN;
      ST_S_SCAN: state_d = status_i.j_end ? ST_S_NEXT : ST_S_CMP;
      ST_S_CMP:  state_d = ST_S_SCAN;
      ST_M_NEXT: state_d = status_i.b_end ? ST_IDLE : ST_M_LAT;
      ST_M_LAT:  state_d = ST_M_SCAN;
      ST_M_SCAN: state_d = status_i.r_end ? ST_M_NEXT : ST_M_CMP;
      ST_M_CMP:  state_d = ST_M_SCAN;
      ST_Q_BS:   state_d = status_i.lo_lt_hi ? ST_Q_BSC : ST_Q_SC;
      ST_Q_BSC:  state_d = ST_Q_BS;
      ST_Q_SC:   state_d = status_i.scan_stop ? ST_Q_FIN : ST_Q_SCC;
      ST_Q_SCC: begin
        if (status_i.past_end) state_d = ST_Q_FIN;
        else if (status_i.below) state_d = ST_Q_SC;
        else state_d = ST_Q_MEM;
      end
      ST_Q_MEM:  state_d = status_i.mem_done ? ST_Q_SC : ST_Q_EMIT;
      ST_Q_EMIT: state_d = status_i.emit_stall ? ST_Q_EMIT : ST_Q_MEM;
      ST_Q_FIN:  state_d = status_i.out_free ? ST_IDLE : ST_Q_FIN;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE:   cmd_o.op = in_valid_i ? OP_ACCEPT : OP_NOP;
      ST_G_NEXT: cmd_o.op = OP_G_NEXT;
      ST_G_LAT:  cmd_o.op = OP_G_LAT;
      ST_G_SCAN: cmd_o.op = OP_G_SCAN;
      ST_G_CMP:  cmd_o.op = OP_G_CMP;
      ST_S_NEXT: cmd_o.op = OP_S_NEXT;
      ST_S_LAT:  cmd_o.op = OP_S_LAT;
      ST_S_SCAN: cmd_o.op = OP_S_SCAN;
      ST_S_CMP:  cmd_o.op = OP_S_CMP;
      ST_M_NEXT: cmd_o.op = OP_M_NEXT;
      ST_M_LAT:  cmd_o.op = OP_M_LAT;
      ST_M_SCAN: cmd_o.op = OP_M_SCAN;
      ST_M_CMP:  cmd_o.op = OP_M_CMP;
      ST_Q_BS:   cmd_o.op = OP_Q_BS;
      ST_Q_BSC:  cmd_o.op = OP_Q_BSC;
      ST_Q_SC:   cmd_o.op = OP_Q_SC;
      ST_Q_SCC:  cmd_o.op = OP_Q_SCC;
      ST_Q_MEM:  cmd_o.op = OP_Q_MEM;
      ST_Q_EMIT: cmd_o.op = OP_Q_EMIT;
      ST_Q_FIN:  cmd_o.op = OP_Q_FIN;
      default:   cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// ===== design/rbii_dp.sv =====
// rbii_dp: record store, band tables, member list, counters and result register
// depends on rbii_pkg and rbii_ram

module rbii_dp import rbii_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] item_index_i,
  input  logic signed [15:0] row_number_i,
  input  logic signed [31:0] rect_top_i,
  input  logic signed [31:0] rect_bottom_i,
  input  logic signed [31:0] rect_width_i,
  input  logic signed [31:0] range_start_i,
  input  logic signed [31:0] range_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] hit_index_o,
  output logic               hit_valid_o,
  output logic               last_hit_o
);

  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  logic [CNT_W-1:0] rec_cnt_q, rec_cnt_d, band_cnt_q, band_cnt_d;
  logic [CNT_W-1:0] r_q, r_d, j_q, j_d, b_q, b_d, rank_q, rank_d, fill_q, fill_d;
  logic [CNT_W-1:0] mstart_q, mstart_d, mcnt_q, mcnt_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, p_q, p_d, k_q, k_d;
  logic [LIM_W-1:0] n_q, n_d;
  band_t            h_q, h_d;
  logic signed [31:0] qs_q, qs_d, qe_q, qe_d;
  logic               pend_q, pend_d;
  logic signed [31:0] pend_idx_q, pend_idx_d;
  logic               out_valid_q, out_valid_d, out_hv_q, out_hv_d, out_last_q, out_last_d;
  logic signed [31:0] out_idx_q, out_idx_d;
  logic               load_out;

  logic rec_we, rec_re, ub_we, ub_re, sb_we, sb_re, ml_we, ml_re;
  logic [AW-1:0] rec_wa, rec_ra, ub_wa, ub_ra, sb_wa, sb_ra, ml_wa, ml_ra;
  rec_t   rec_wd, rec_rd;
  band_t  ub_wd, ub_rd;
  sband_t sb_wd, sb_rd;
  logic [31:0] ml_wd, ml_rd;
  logic [CNT_W-1:0] mid_c;
  logic out_free, n_full, add_ok;

  rbii_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_RECORDS)) u_rec_ram (
    .clk_i, .we_i(rec_we), .waddr_i(rec_wa), .wdata_i(rec_wd),
    .re_i(rec_re), .raddr_i(rec_ra), .rdata_o(rec_rd)
  );
  rbii_ram #(.WIDTH($bits(band_t)), .DEPTH(MAX_RECORDS)) u_ub_ram (
    .clk_i, .we_i(ub_we), .waddr_i(ub_wa), .wdata_i(ub_wd),
    .re_i(ub_re), .raddr_i(ub_ra), .rdata_o(ub_rd)
  );
  rbii_ram #(.WIDTH($bits(sband_t)), .DEPTH(MAX_RECORDS)) u_sb_ram (
    .clk_i, .we_i(sb_we), .waddr_i(sb_wa), .wdata_i(sb_wd),
    .re_i(sb_re), .raddr_i(sb_ra), .rdata_o(sb_rd)
  );
  rbii_ram #(.WIDTH(32), .DEPTH(MAX_RECORDS)) u_ml_ram (
    .clk_i, .we_i(ml_we), .waddr_i(ml_wa), .wdata_i(ml_wd),
    .re_i(ml_re), .raddr_i(ml_ra), .rdata_o(ml_rd)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign n_full   = (n_q == LIM_W'(RESULT_LIMIT));
  assign add_ok   = !item_index_i[31] && (rect_width_i > 0) && (rect_bottom_i > rect_top_i)
                    && (rec_cnt_q != CNT_W'(MAX_RECORDS));
  assign mid_c    = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    status_o.r_end      = (r_q == rec_cnt_q);
    status_o.j_end      = (j_q == band_cnt_q);
    status_o.b_end      = (b_q == band_cnt_q);
    status_o.row_match  = (ub_rd.row == h_q.row);
    status_o.lo_lt_hi   = (lo_q < hi_q);
    status_o.scan_stop  = (b_q == band_cnt_q) || n_full;
    status_o.past_end   = (sb_rd.b.top > qe_q);
    status_o.below      = (sb_rd.b.bot < qs_q);
    status_o.mem_done   = (k_q == '0) || n_full;
    status_o.emit_stall = pend_q && !out_free;
    status_o.out_free   = out_free;
  end

  always_comb begin
    rec_cnt_d = rec_cnt_q; band_cnt_d = band_cnt_q;
    r_d = r_q; j_d = j_q; b_d = b_q; rank_d = rank_q; fill_d = fill_q;
    mstart_d = mstart_q; mcnt_d = mcnt_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; p_d = p_q; k_d = k_q; n_d = n_q;
    h_d = h_q; qs_d = qs_q; qe_d = qe_q;
    pend_d = pend_q; pend_idx_d = pend_idx_q;
    out_idx_d = out_idx_q; out_hv_d = out_hv_q; out_last_d = out_last_q;
    load_out = 1'b0;
    rec_we = 1'b0; rec_re = 1'b0; ub_we = 1'b0; ub_re = 1'b0;
    sb_we = 1'b0; sb_re = 1'b0; ml_we = 1'b0; ml_re = 1'b0;
    rec_wa = rec_cnt_q[AW-1:0]; rec_ra = r_q[AW-1:0];
    ub_wa = band_cnt_q[AW-1:0]; ub_ra = j_q[AW-1:0];
    sb_wa = rank_q[AW-1:0]; sb_ra = b_q[AW-1:0];
    ml_wa = fill_q[AW-1:0]; ml_ra = p_q[AW-1:0];
    rec_wd = '{idx: item_index_i, row: row_number_i, top: rect_top_i, bot: rect_bottom_i};
    ub_wd = h_q;
    sb_wd = '{b: h_q, mstart: mstart_q, mcnt: mcnt_q};
    ml_wd = rec_rd.idx;
    case (cmd_i.op)
      OP_ACCEPT: begin
        case (opcode_e'(opcode_i))
          OPC_CLEAR: begin
            rec_cnt_d = '0;
            band_cnt_d = '0;
          end
          OPC_ADD: begin
            if (add_ok) begin
              rec_we = 1'b1;
              rec_cnt_d = rec_cnt_q + ONE;
            end
          end
          OPC_BUILD: begin
            band_cnt_d = '0;
            r_d = '0;
          end
          OPC_QUERY: begin
            if (range_end_i < range_start_i) begin
              qs_d = range_end_i;
              qe_d = range_start_i;
            end else begin
              qs_d = range_start_i;
              qe_d = range_end_i;
            end
            lo_d = '0;
            hi_d = band_cnt_q;
            n_d = '0;
            pend_d = 1'b0;
          end
          default: ;
        endcase
      end
      OP_G_NEXT: begin
        if (r_q == rec_cnt_q) b_d = '0;
        else rec_re = 1'b1;
      end
      OP_G_LAT: begin
        h_d = '{row: rec_rd.row, top: rec_rd.top, bot: rec_rd.bot};
        j_d = '0;
      end
      OP_G_SCAN: begin
        if (j_q == band_cnt_q) begin
          ub_we = 1'b1;
          band_cnt_d = band_cnt_q + ONE;
          r_d = r_q + ONE;
        end else begin
          ub_re = 1'b1;
        end
      end
      OP_G_CMP: begin
        if (ub_rd.row == h_q.row) begin
          ub_we = 1'b1;
          ub_wa = j_q[AW-1:0];
          ub_wd = '{row: ub_rd.row,
                    top: (h_q.top < ub_rd.top) ? h_q.top : ub_rd.top,
                    bot: (h_q.bot > ub_rd.bot) ? h_q.bot : ub_rd.bot};
          r_d = r_q + ONE;
        end else begin
          j_d = j_q + ONE;
        end
      end
      OP_S_NEXT: begin
        if (b_q == band_cnt_q) begin
          b_d = '0;
          fill_d = '0;
        end else begin
          ub_re = 1'b1;
          ub_ra = b_q[AW-1:0];
        end
      end
      OP_S_LAT: begin
        h_d = ub_rd;
        j_d = '0;
        rank_d = '0;
      end
      OP_S_SCAN: begin
        if (j_q == band_cnt_q) begin
          sb_we = 1'b1;
          b_d = b_q + ONE;
        end else begin
          ub_re = 1'b1;
        end
      end
      OP_S_CMP: begin
        if (band_less(ub_rd, h_q)) rank_d = rank_q + ONE;
        j_d = j_q + ONE;
      end
      OP_M_NEXT: begin
        if (b_q != band_cnt_q) sb_re = 1'b1;
      end
      OP_M_LAT: begin
        h_d = sb_rd.b;
        mstart_d = fill_q;
        mcnt_d = '0;
        r_d = '0;
      end
      OP_M_SCAN: begin
        if (r_q == rec_cnt_q) begin
          sb_we = 1'b1;
          sb_wa = b_q[AW-1:0];
          b_d = b_q + ONE;
        end else begin
          rec_re = 1'b1;
        end
      end
      OP_M_CMP: begin
        if (rec_rd.row == h_q.row && fill_q != CNT_W'(MAX_RECORDS)) begin
          ml_we = 1'b1;
          fill_d = fill_q + ONE;
          mcnt_d = mcnt_q + ONE;
        end
        r_d = r_q + ONE;
      end
      OP_Q_BS: begin
        if (lo_q < hi_q) begin
          mid_d = mid_c;
          sb_re = 1'b1;
          sb_ra = mid_c[AW-1:0];
        end else begin
          b_d = lo_q;
        end
      end
      OP_Q_BSC: begin
        if (sb_rd.b.bot < qs_q) lo_d = mid_q + ONE;
        else hi_d = mid_q;
      end
      OP_Q_SC: begin
        if (!((b_q == band_cnt_q) || n_full)) sb_re = 1'b1;
      end
      OP_Q_SCC: begin
        if (!(sb_rd.b.top > qe_q)) begin
          b_d = b_q + ONE;
          if (!(sb_rd.b.bot < qs_q)) begin
            p_d = sb_rd.mstart;
            k_d = sb_rd.mcnt;
          end
        end
      end
      OP_Q_MEM: begin
        if (!((k_q == '0) || n_full)) ml_re = 1'b1;
      end
      OP_Q_EMIT: begin
        if (!(pend_q && !out_free)) begin
          if (pend_q) begin
            load_out = 1'b1;
            out_idx_d = pend_idx_q;
            out_hv_d = 1'b1;
            out_last_d = 1'b0;
          end
          pend_d = 1'b1;
          pend_idx_d = ml_rd;
          n_d = n_q + LIM_W'(1);
          p_d = p_q + ONE;
          k_d = k_q - ONE;
        end
      end
      OP_Q_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          out_idx_d = pend_q ? pend_idx_q : '0;
          out_hv_d = pend_q;
          out_last_d = 1'b1;
          pend_d = 1'b0;
        end
      end
      default: ;
    endcase
    if (load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_cnt_q <= '0;
      band_cnt_q <= '0;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      n_q <= '0;
      fill_q <= '0;
    end else begin
      rec_cnt_q <= rec_cnt_d;
      band_cnt_q <= band_cnt_d;
      pend_q <= pend_d;
      out_valid_q <= out_valid_d;
      n_q <= n_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; j_q <= j_d; b_q <= b_d; rank_q <= rank_d;
    mstart_q <= mstart_d; mcnt_q <= mcnt_d;
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d; p_q <= p_d; k_q <= k_d;
    h_q <= h_d; qs_q <= qs_d; qe_q <= qe_d; pend_idx_q <= pend_idx_d;
    out_idx_q <= out_idx_d; out_hv_q <= out_hv_d; out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign hit_index_o = out_idx_q;
  assign hit_valid_o = out_hv_q;
  assign last_hit_o  = out_last_q;

  a_rec_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_cnt_q <= CNT_W'(MAX_RECORDS)) else $error("record count past capacity");
  a_band_le_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    band_cnt_q <= rec_cnt_q) else $error("more bands than records");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free) else $error("result register overwritten");
  a_hit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= LIM_W'(RESULT_LIMIT)) else $error("hit count past limit");

endmodule

// ===== design/row_band_interval_index_top.sv =====
// row_band_interval_index_top: band index over laid-out records, range queries
// depends on rbii_pkg, rbii_ctrl, rbii_dp (which holds the rbii_ram instances)
//
//   channel  | handshake                | payload
//   request  | in_valid_i / in_ready_o  | opcode_i, item_index_i, row_number_i, rect_*_i,
//            |                          | range_start_i, range_end_i
//   result   | out_valid_o / out_ready_i| hit_index_o, hit_valid_o, last_hit_o
//
// clear and add complete on acceptance; one request is worked on at a time
// build runs a grouping, a sorting and a member pass, paced
//   by the single read port of the record and band rams walked by the sequencer
// query: a binary search over the sorted bands, then a scan of bands and of the
//   members of each hit band, plus stalls
// the query stalls while an untaken result is held and either a hit is pending with another
//   hit ready, or the final result is ready; no clearing pass at reset

module row_band_interval_index_top import rbii_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] item_index_i,
  input  logic signed [15:0] row_number_i,
  input  logic signed [31:0] rect_top_i,
  input  logic signed [31:0] rect_bottom_i,
  input  logic signed [31:0] rect_width_i,
  input  logic signed [31:0] range_start_i,
  input  logic signed [31:0] range_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] hit_index_o,
  output logic               hit_valid_o,
  output logic               last_hit_o
);

  cmd_t    cmd;
  status_t status;

  rbii_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .opcode_i,
    .status_i(status), .in_ready_o, .cmd_o(cmd)
  );

  rbii_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .opcode_i,
    .item_index_i, .row_number_i, .rect_top_i, .rect_bottom_i, .rect_width_i,
    .range_start_i, .range_end_i,
    .out_valid_o, .out_ready_i, .hit_index_o, .hit_valid_o, .last_hit_o
  );

endmodule
